FILE: rtl/kct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed counter table package
// Shared sizes, codes and control types of the keyed counter table.
// ----------------------------------------------------------------------------
package kct_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int TOP_K       = 3;

  localparam int KEY_W    = 64;
  localparam int CNT_W    = 32;
  localparam int STATUS_W = 3;
  localparam int RANK_W   = 2;
  localparam int ENTRY_W  = KEY_W + CNT_W;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
  localparam int RND_W  = $clog2(TOP_K + 1);
  localparam int IDX_W  = (TOP_K > 1) ? $clog2(TOP_K) : 1;

  localparam int OUT_FIELDS_W = RANK_W + KEY_W + CNT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  typedef enum logic [STATUS_W-1:0] {
    ST_INC   = 3'd0,
    ST_NEW   = 3'd1,
    ST_DROP  = 3'd2,
    ST_RANK  = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CNT_SCAN,
    S_RPT_START,
    S_RPT_SCAN,
    S_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic count_hit;
    logic count_miss;
    logic scan_start;
    logic round_done;
    logic res_empty;
    logic res_rank;
  } ctl_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic rd_vld;
    logic rounds_done;
    logic empty;
    logic out_last;
  } ctl_stat_t;

endpackage
`default_nettype wire

FILE: rtl/kct_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: rtl/kct_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed counter table controller
// Sequences table searches, ranking rounds and result delivery.
// ----------------------------------------------------------------------------
module kct_ctrl
  import kct_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  input  wire logic      in_report,
  output logic           in_tready,
  output logic           out_tvalid,
  input  wire logic      out_tready,
  input  wire ctl_stat_t stat,
  output ctl_cmd_t       cmd
);

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = in_report ? S_RPT_START : S_CNT_SCAN;
        end
      end
      S_CNT_SCAN: begin
        priority if (stat.hit) begin
          cmd.count_hit = 1'b1;
          state_nxt     = S_EMIT;
        end else if (stat.scan_end && !stat.rd_vld) begin
          cmd.count_miss = 1'b1;
          state_nxt      = S_EMIT;
        end else begin
          cmd.issue = !stat.scan_end;
        end
      end
      S_RPT_START: begin
        priority if (stat.empty) begin
          cmd.res_empty = 1'b1;
          state_nxt     = S_EMIT;
        end else if (stat.rounds_done) begin
          cmd.res_rank = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_RPT_SCAN;
        end
      end
      S_RPT_SCAN: begin
        if (stat.scan_end && !stat.rd_vld) begin
          cmd.round_done = 1'b1;
          state_nxt      = S_RPT_START;
        end else begin
          cmd.issue = !stat.scan_end;
        end
      end
      S_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (stat.out_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.res_rank = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/kct_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed counter table datapath
// Holds the table memory, the scan pipeline, the ranking registers and the
// result register.
// ----------------------------------------------------------------------------
module kct_dp
  import kct_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [KEY_W-1:0] in_key,
  input  wire ctl_cmd_t         cmd,
  output ctl_stat_t             stat,
  output status_t               out_status,
  output logic      [RANK_W-1:0] out_rank,
  output logic      [KEY_W-1:0] out_key,
  output logic      [CNT_W-1:0] out_count,
  output logic                  out_last
);

  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] scan_r;
  logic [RND_W-1:0]  round_r;
  logic [RND_W-1:0]  emit_r;
  logic [KEY_W-1:0]  key_r;
  logic              rd_vld_r;
  logic [ADDR_W-1:0] rd_pos_r;

  logic [ADDR_W-1:0] swap_r [TOP_K];
  logic [KEY_W-1:0]  top_key_r [TOP_K];
  logic [CNT_W-1:0]  top_cnt_r [TOP_K];

  logic [ADDR_W-1:0] best_pos_r;
  logic [KEY_W-1:0]  best_key_r;
  logic [CNT_W-1:0]  best_cnt_r;

  status_t           res_status_r;
  logic [RANK_W-1:0] res_rank_r;
  logic [KEY_W-1:0]  res_key_r;
  logic [CNT_W-1:0]  res_cnt_r;
  logic              res_last_r;

  logic [ENTRY_W-1:0] rd_data;
  logic [KEY_W-1:0]   rd_key;
  logic [CNT_W-1:0]   rd_cnt;
  logic [CNT_W-1:0]   inc_cnt;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               full;
  logic [RND_W-1:0]   round_lim;
  logic [IDX_W-1:0]   round_idx;
  logic [IDX_W-1:0]   emit_idx;

  assign rd_key    = rd_data[KEY_W-1:0];
  assign rd_cnt    = rd_data[ENTRY_W-1:KEY_W];
  assign inc_cnt   = (rd_cnt == {CNT_W{1'b1}}) ? rd_cnt : rd_cnt + CNT_W'(1);
  assign full      = (fill_r == FILL_W'(TABLE_DEPTH));
  assign round_lim = (fill_r < FILL_W'(TOP_K)) ? RND_W'(fill_r) : RND_W'(TOP_K);
  assign round_idx = round_r[IDX_W-1:0];
  assign emit_idx  = emit_r[IDX_W-1:0];

  // The ranked copy is never stored. Each earlier round swapped its position
  // with the position of its winner, so a position of the copy is mapped back
  // to a table address by undoing those swaps, the latest one first.
  always_comb begin
    rd_addr = scan_r[ADDR_W-1:0];
    for (int k = TOP_K - 1; k >= 0; k--) begin
      if (RND_W'(k) < round_r) begin
        if (rd_addr == ADDR_W'(k)) begin
          rd_addr = swap_r[k];
        end else if (rd_addr == swap_r[k]) begin
          rd_addr = ADDR_W'(k);
        end
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_pos_r;
    wr_data = {inc_cnt, key_r};
    if (cmd.count_hit) begin
      wr_en = 1'b1;
    end else if (cmd.count_miss && !full) begin
      wr_en   = 1'b1;
      wr_addr = fill_r[ADDR_W-1:0];
      wr_data = {CNT_W'(1), key_r};
    end
  end

  kct_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (cmd.issue),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      rd_vld_r <= 1'b0;
      scan_r   <= '0;
      round_r  <= '0;
      emit_r   <= '0;
    end else begin
      rd_vld_r <= cmd.issue;
      if (cmd.load) begin
        scan_r  <= '0;
        round_r <= '0;
        emit_r  <= '0;
      end
      if (cmd.scan_start) begin
        scan_r <= FILL_W'(round_r);
      end
      if (cmd.issue) begin
        scan_r <= scan_r + FILL_W'(1);
      end
      if (cmd.round_done) begin
        round_r <= round_r + RND_W'(1);
      end
      if (cmd.res_rank) begin
        emit_r <= emit_r + RND_W'(1);
      end
      if (cmd.count_miss && !full) begin
        fill_r <= fill_r + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_key;
    end
    if (cmd.issue) begin
      rd_pos_r <= scan_r[ADDR_W-1:0];
    end
    if (rd_vld_r && ((FILL_W'(rd_pos_r) == FILL_W'(round_r)) || (rd_cnt > best_cnt_r))) begin
      best_pos_r <= rd_pos_r;
      best_key_r <= rd_key;
      best_cnt_r <= rd_cnt;
    end
    if (cmd.round_done) begin
      swap_r[round_idx]    <= best_pos_r;
      top_key_r[round_idx] <= best_key_r;
      top_cnt_r[round_idx] <= best_cnt_r;
    end
    priority if (cmd.count_hit) begin
      res_status_r <= ST_INC;
      res_rank_r   <= '0;
      res_key_r    <= key_r;
      res_cnt_r    <= inc_cnt;
      res_last_r   <= 1'b1;
    end else if (cmd.count_miss) begin
      res_status_r <= full ? ST_DROP : ST_NEW;
      res_rank_r   <= '0;
      res_key_r    <= key_r;
      res_cnt_r    <= full ? '0 : CNT_W'(1);
      res_last_r   <= 1'b1;
    end else if (cmd.res_empty) begin
      res_status_r <= ST_EMPTY;
      res_rank_r   <= '0;
      res_key_r    <= '0;
      res_cnt_r    <= '0;
      res_last_r   <= 1'b1;
    end else if (cmd.res_rank) begin
      res_status_r <= ST_RANK;
      res_rank_r   <= RANK_W'(emit_r);
      res_key_r    <= top_key_r[emit_idx];
      res_cnt_r    <= top_cnt_r[emit_idx];
      res_last_r   <= (emit_r + RND_W'(1) == round_r);
    end
  end

  assign stat.hit         = rd_vld_r && (rd_key == key_r);
  assign stat.scan_end    = (scan_r == fill_r);
  assign stat.rd_vld      = rd_vld_r;
  assign stat.rounds_done = (round_r == round_lim);
  assign stat.empty       = (fill_r == '0);
  assign stat.out_last    = res_last_r;

  assign out_status = res_status_r;
  assign out_rank   = res_rank_r;
  assign out_key    = res_key_r;
  assign out_count  = res_cnt_r;
  assign out_last   = res_last_r;

`ifndef SYNTHESIS
  a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.count_miss && !full) |=> (fill_r == $past(fill_r) + FILL_W'(1)))
    else $error("Fill level did not advance after a new key was stored.");

  a_read_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (FILL_W'(rd_pos_r) < fill_r))
    else $error("A table read went past the filled entries.");

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.round_done |-> ((FILL_W'(round_r) < fill_r) && (round_r < RND_W'(TOP_K))))
    else $error("A ranking round ran beyond the table or the ranking depth.");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.count_hit && cmd.count_miss))
    else $error("A count request both hit and missed.");
`endif

endmodule
`default_nettype wire

FILE: rtl/keyed_counter_table_top_three_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed counter table with top three report
// Counts requests per 64-bit key in a table filled in order of arrival and
// reports the most active keys on request.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  in_*      input      tuser: cmd (report when set); tdata: channel_key
//  out_*     output     tuser: status; tdata: rank, ranked_key, ranked_count;
//                       tlast: last
//
//  A count request searches the table memory one entry per cycle through its
//  single read port, and then waits for its result to be taken. A report runs
//  one search pass over the table per rank, then delivers one ranked result
//  per cycle that out_tready allows. Reset clears the fill level and the
//  scan, round and emit counters, not the table; no clearing pass is needed.
//  One request is handled at a time, and in_tready is low until the last
//  result of the current request has been taken.
// ----------------------------------------------------------------------------
module keyed_counter_table_top_three_core
  import kct_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [KEY_W-1:0]      in_tdata,   // [63:0] channel_key
  input  wire logic                  in_tuser,   // [0] cmd
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,  // [1:0] rank, [65:2] ranked_key,
                                                 // [97:66] ranked_count, rest zero
  output logic      [STATUS_W-1:0]   out_tuser,  // [2:0] status
  output logic                       out_tlast
);

  ctl_cmd_t          cmd;
  ctl_stat_t         stat;
  status_t           res_status;
  logic [RANK_W-1:0] res_rank;
  logic [KEY_W-1:0]  res_key;
  logic [CNT_W-1:0]  res_count;
  logic              res_last;

  kct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_report (in_tuser),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  kct_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_key    (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_status(res_status),
    .out_rank  (res_rank),
    .out_key   (res_key),
    .out_count (res_count),
    .out_last  (res_last)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, res_count, res_key, res_rank};
  assign out_tuser = res_status;
  assign out_tlast = res_last;

endmodule
`default_nettype wire
